// ===== rtl/poll_retry_timeout_master_fsm_core_macros.svh =====
// Assertion macros shared by the poll, retry and timeout controller RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef POLL_RETRY_TIMEOUT_MASTER_FSM_CORE_MACROS_SVH
`define POLL_RETRY_TIMEOUT_MASTER_FSM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRTM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRTM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/prtm_pkg.sv =====
// Package for the poll, retry and timeout controller: codes, types and helpers.
// Used by prtm_step, prtm_obuf and poll_retry_timeout_master_fsm_core.
package prtm_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int TO_W          = 16;
	localparam int ATT_W         = 4;
	localparam int MAX_RES       = 3;

	// Configuration register indexes.
	localparam logic [2:0] REG_TO_DATA     = 3'd0;
	localparam logic [2:0] REG_TO_ACK      = 3'd1;
	localparam logic [2:0] REG_TO_FAILURES = 3'd2;
	localparam logic [2:0] REG_TO_CAPACITY = 3'd3;
	localparam logic [2:0] REG_TO_RECON    = 3'd4;
	localparam logic [2:0] REG_MAX_ATT     = 3'd5;

	localparam logic [TO_W-1:0]  TO_RESET      = 16'd1000;
	localparam logic [ATT_W-1:0] MAX_ATT_RESET = 4'd3;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DATA     = 7'b0000010,
		ST_ACKDIR   = 7'b0000100,
		ST_FAIL     = 7'b0001000,
		ST_CAP      = 7'b0010000,
		ST_RECON    = 7'b0100000,
		ST_ACKRECON = 7'b1000000
	} fsm_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_CLKRST    = 4'd1,
		EV_DIRECTIVE = 4'd2,
		EV_MEASURE   = 4'd3,
		EV_FAILURES  = 4'd4,
		EV_CAPACITY  = 4'd5,
		EV_RECON     = 4'd6,
		EV_DATA      = 4'd7,
		EV_ACK       = 4'd8,
		EV_FAILRX    = 4'd9,
		EV_CAPRX     = 4'd10,
		EV_RECONRX   = 4'd11
	} event_t;

	typedef enum logic [2:0] {
		ACT_CLKRST    = 3'd0,
		ACT_OK        = 3'd1,
		ACT_DIRECTIVE = 3'd2,
		ACT_POLL      = 3'd3,
		ACT_ERROR     = 3'd4,
		ACT_ACK3      = 3'd5,
		ACT_ACK1      = 3'd6,
		ACT_FORWARD   = 3'd7
	} action_t;

	localparam logic [2:0] CODE_IDLE     = 3'd0;
	localparam logic [2:0] CODE_DATA     = 3'd1;
	localparam logic [2:0] CODE_ACKDIR   = 3'd2;
	localparam logic [2:0] CODE_FAIL     = 3'd3;
	localparam logic [2:0] CODE_CAP      = 3'd4;
	localparam logic [2:0] CODE_RECON    = 3'd5;
	localparam logic [2:0] CODE_ACKRECON = 3'd6;

	typedef struct packed {
		logic [TO_W-1:0]  to_data;
		logic [TO_W-1:0]  to_ack;
		logic [TO_W-1:0]  to_failures;
		logic [TO_W-1:0]  to_capacity;
		logic [TO_W-1:0]  to_recon;
		logic [ATT_W-1:0] max_att;
	} cfg_t;

	typedef struct packed {
		action_t    action;
		logic [2:0] state_code;
	} res_t;

	// Outcome of one step, apart from the arm time, which is loaded from the item's time.
	typedef struct packed {
		fsm_t             state;
		logic [ATT_W-1:0] attempt;
		logic             arm_load;
		logic [1:0]       num;
		res_t [MAX_RES-1:0] res;
	} step_t;

	function automatic logic [2:0] state_code(input fsm_t st);
		logic [2:0] c;
		case (st)
			ST_DATA:     c = CODE_DATA;
			ST_ACKDIR:   c = CODE_ACKDIR;
			ST_FAIL:     c = CODE_FAIL;
			ST_CAP:      c = CODE_CAP;
			ST_RECON:    c = CODE_RECON;
			ST_ACKRECON: c = CODE_ACKRECON;
			default:     c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/prtm_step.sv =====
// Next-state and action logic of the controller for one registered item.
// Depends on prtm_pkg.
module prtm_step #(
	parameter int TIME_BITS = prtm_pkg::TIME_BITS_DEF
) (
	input  prtm_pkg::fsm_t                   state,
	input  logic [TIME_BITS-1:0]             arm_time,
	input  logic [prtm_pkg::ATT_W-1:0]       attempt,
	input  prtm_pkg::cfg_t                   cfg,
	input  logic [TIME_BITS-1:0]             now,
	input  logic [3:0]                       ev,
	output prtm_pkg::step_t                  nxt
);

	logic [TIME_BITS-1:0]       elapsed;
	logic [prtm_pkg::TO_W-1:0]  limit;
	logic                       timed_out;
	logic                       gave_up;
	logic [1:0]                 n;
	prtm_pkg::event_t           evt;

	assign elapsed   = now - arm_time;
	assign evt       = prtm_pkg::event_t'(ev);
	assign timed_out = elapsed >= TIME_BITS'(limit);

	always_comb begin
		case (state)
			prtm_pkg::ST_DATA:     limit = cfg.to_data;
			prtm_pkg::ST_ACKDIR:   limit = cfg.to_ack;
			prtm_pkg::ST_FAIL:     limit = cfg.to_failures;
			prtm_pkg::ST_CAP:      limit = cfg.to_capacity;
			prtm_pkg::ST_RECON:    limit = cfg.to_recon;
			prtm_pkg::ST_ACKRECON: limit = cfg.to_ack;
			default:               limit = '0;
		endcase
	end

	always_comb begin
		nxt.state    = state;
		nxt.attempt  = attempt;
		nxt.arm_load = 1'b0;
		nxt.res      = '0;
		n            = 2'd0;
		gave_up      = 1'b0;
		case (state)
			prtm_pkg::ST_DATA, prtm_pkg::ST_ACKDIR, prtm_pkg::ST_FAIL,
			prtm_pkg::ST_CAP, prtm_pkg::ST_RECON: begin
				if (timed_out) begin
					if (attempt < cfg.max_att) begin
						nxt.arm_load = 1'b1;
						nxt.attempt  = attempt + 4'd1;
						// Only the polled and directive requests are resent visibly.
						if (state == prtm_pkg::ST_DATA) begin
							nxt.res[n] = '{prtm_pkg::ACT_POLL, prtm_pkg::CODE_DATA};
							n = n + 2'd1;
						end else if (state == prtm_pkg::ST_ACKDIR) begin
							nxt.res[n] = '{prtm_pkg::ACT_DIRECTIVE, prtm_pkg::CODE_ACKDIR};
							n = n + 2'd1;
						end
					end else begin
						gave_up   = 1'b1;
						nxt.state = prtm_pkg::ST_IDLE;
						if (state == prtm_pkg::ST_DATA || state == prtm_pkg::ST_ACKDIR) begin
							nxt.res[n] = '{prtm_pkg::ACT_ERROR, prtm_pkg::CODE_IDLE};
							n = n + 2'd1;
						end
					end
				end
				if (!gave_up) begin
					if (state == prtm_pkg::ST_DATA && evt == prtm_pkg::EV_DATA) begin
						nxt.state  = prtm_pkg::ST_IDLE;
						nxt.res[n] = '{prtm_pkg::ACT_FORWARD, prtm_pkg::CODE_IDLE};
						n = n + 2'd1;
						nxt.res[n] = '{prtm_pkg::ACT_ACK3, prtm_pkg::CODE_IDLE};
						n = n + 2'd1;
					end else if (state == prtm_pkg::ST_ACKDIR && evt == prtm_pkg::EV_ACK) begin
						nxt.state  = prtm_pkg::ST_IDLE;
						nxt.res[n] = '{prtm_pkg::ACT_OK, prtm_pkg::CODE_IDLE};
						n = n + 2'd1;
						nxt.res[n] = '{prtm_pkg::ACT_ACK3, prtm_pkg::CODE_IDLE};
						n = n + 2'd1;
					end else if ((state == prtm_pkg::ST_FAIL && evt == prtm_pkg::EV_FAILRX) ||
						(state == prtm_pkg::ST_CAP && evt == prtm_pkg::EV_CAPRX)) begin
						nxt.state  = prtm_pkg::ST_IDLE;
						nxt.res[n] = '{prtm_pkg::ACT_ACK3, prtm_pkg::CODE_IDLE};
						n = n + 2'd1;
					end else if (state == prtm_pkg::ST_RECON && evt == prtm_pkg::EV_RECONRX) begin
						nxt.state    = prtm_pkg::ST_ACKRECON;
						nxt.arm_load = 1'b1;
					end
				end
			end
			prtm_pkg::ST_ACKRECON: begin
				if (timed_out) begin
					nxt.state  = prtm_pkg::ST_IDLE;
					nxt.res[n] = '{prtm_pkg::ACT_ERROR, prtm_pkg::CODE_IDLE};
					n = n + 2'd1;
				end else if (evt == prtm_pkg::EV_ACK) begin
					nxt.state  = prtm_pkg::ST_IDLE;
					nxt.res[n] = '{prtm_pkg::ACT_ACK1, prtm_pkg::CODE_IDLE};
					n = n + 2'd1;
				end
			end
			default: begin
				nxt.state = prtm_pkg::ST_IDLE;
				case (evt)
					prtm_pkg::EV_CLKRST: begin
						nxt.res[0] = '{prtm_pkg::ACT_CLKRST, prtm_pkg::CODE_IDLE};
						nxt.res[1] = '{prtm_pkg::ACT_OK, prtm_pkg::CODE_IDLE};
						n = 2'd2;
					end
					prtm_pkg::EV_DIRECTIVE: begin
						nxt.state    = prtm_pkg::ST_ACKDIR;
						nxt.arm_load = 1'b1;
						nxt.attempt  = 4'd1;
						nxt.res[0]   = '{prtm_pkg::ACT_DIRECTIVE, prtm_pkg::CODE_ACKDIR};
						n = 2'd1;
					end
					prtm_pkg::EV_MEASURE: begin
						nxt.state    = prtm_pkg::ST_DATA;
						nxt.arm_load = 1'b1;
						nxt.attempt  = 4'd1;
						nxt.res[0]   = '{prtm_pkg::ACT_POLL, prtm_pkg::CODE_DATA};
						n = 2'd1;
					end
					prtm_pkg::EV_FAILURES: begin
						nxt.state    = prtm_pkg::ST_FAIL;
						nxt.arm_load = 1'b1;
						nxt.attempt  = 4'd1;
					end
					prtm_pkg::EV_CAPACITY: begin
						nxt.state    = prtm_pkg::ST_CAP;
						nxt.arm_load = 1'b1;
						nxt.attempt  = 4'd1;
					end
					prtm_pkg::EV_RECON: begin
						nxt.state    = prtm_pkg::ST_RECON;
						nxt.arm_load = 1'b1;
						nxt.attempt  = 4'd1;
					end
					default: begin
					end
				endcase
			end
		endcase
		nxt.num = n;
	end

endmodule

// ===== rtl/prtm_obuf.sv =====
// Result register of the controller: holds the actions of one item and drains them in order.
// Depends on prtm_pkg.
module prtm_obuf (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [1:0]                          num,
	input  prtm_pkg::res_t [prtm_pkg::MAX_RES-1:0] res,
	output logic                                free,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          action,
	output logic [2:0]                          state_after,
	output logic                                last
);

	prtm_pkg::res_t [prtm_pkg::MAX_RES-1:0] ent_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       take;

	assign take        = valid_q && !out_stall;
	assign last        = idx_q == (cnt_q - 2'd1);
	// The buffer takes a new set once the final action of the current one leaves.
	assign free        = !valid_q || (take && last);
	assign out_valid   = valid_q;
	assign action      = ent_q[idx_q].action;
	assign state_after = ent_q[idx_q].state_code;

	always_ff @(posedge clk) begin
		if (load && free) begin
			ent_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else if (load && free && num != 2'd0) begin
			valid_q <= 1'b1;
			cnt_q   <= num;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/poll_retry_timeout_master_fsm_core.sv =====
// Top level of the master-side poll, retry and timeout controller.
// Depends on prtm_pkg, prtm_step, prtm_obuf and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_stall): each transaction carries now_ms, the free-running
//   millisecond time, and event_code. Output channel (out_valid/out_stall): each
//   transaction carries one action, the state right after it, and last, set on the final
//   action caused by an input. An input may cause zero to three actions.
//   Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; cfg_index picks
//   one of the five timeouts or the attempt limit, indexes six and seven are ignored.
//   Write it only while the block is idle.
//   Path: an accepted input is held in the input register and evaluated there; once it
//   commits, its actions go to the result register, from which they are offered in order.
//   Throughput: with out_stall low, one input per cycle when it causes at most one action;
//   an input with more holds the result register until they drain, one action per cycle.
//   The input register frees up as soon as its item moves to the result register, so one
//   further input is accepted while results are still waiting.
//   Reset: the state machine returns to idle, the arm time and attempt count clear, and
//   the timeouts go to 1000 ms and the attempt limit to 3.
//   Stall: while out_stall is high the current action holds; once the result register is full
//   and the input register holds an item with actions, in_stall rises until the result register drains.
`include "poll_retry_timeout_master_fsm_core_macros.svh"

module poll_retry_timeout_master_fsm_core #(
	parameter int TIME_BITS = prtm_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic [3:0]  event_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [2:0]  state_after,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	prtm_pkg::cfg_t cfg_q;

	// Controller state.
	prtm_pkg::fsm_t                 state_q;
	logic [TIME_BITS-1:0]           arm_q;
	logic [prtm_pkg::ATT_W-1:0]     att_q;

	// Input register stage.
	logic                 v_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [3:0]           ev_s1;

	prtm_pkg::step_t nxt;
	logic            ob_free;
	logic            commit;
	logic            in_take;

	assign cfg_ready = 1'b1;

	// An item leaves the input register when it has nothing to show or the result
	// register can take its actions this cycle; the state is updated at that same edge.
	assign commit   = v_s1 && (nxt.num == 2'd0 || ob_free);
	assign in_stall = v_s1 && !commit;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.to_data     <= prtm_pkg::TO_RESET;
			cfg_q.to_ack      <= prtm_pkg::TO_RESET;
			cfg_q.to_failures <= prtm_pkg::TO_RESET;
			cfg_q.to_capacity <= prtm_pkg::TO_RESET;
			cfg_q.to_recon    <= prtm_pkg::TO_RESET;
			cfg_q.max_att     <= prtm_pkg::MAX_ATT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prtm_pkg::REG_TO_DATA:     cfg_q.to_data     <= cfg_data;
				prtm_pkg::REG_TO_ACK:      cfg_q.to_ack      <= cfg_data;
				prtm_pkg::REG_TO_FAILURES: cfg_q.to_failures <= cfg_data;
				prtm_pkg::REG_TO_CAPACITY: cfg_q.to_capacity <= cfg_data;
				prtm_pkg::REG_TO_RECON:    cfg_q.to_recon    <= cfg_data;
				prtm_pkg::REG_MAX_ATT:     cfg_q.max_att     <= cfg_data[prtm_pkg::ATT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (commit) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1 <= now_ms[TIME_BITS-1:0];
			ev_s1  <= event_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prtm_pkg::ST_IDLE;
			arm_q   <= '0;
			att_q   <= '0;
		end else if (commit) begin
			state_q <= nxt.state;
			att_q   <= nxt.attempt;
			if (nxt.arm_load) begin
				arm_q <= now_s1;
			end
		end
	end

	prtm_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.state    (state_q),
		.arm_time (arm_q),
		.attempt  (att_q),
		.cfg      (cfg_q),
		.now      (now_s1),
		.ev       (ev_s1),
		.nxt      (nxt)
	);

	prtm_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (commit),
		.num         (nxt.num),
		.res         (nxt.res),
		.free        (ob_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.action      (action),
		.state_after (state_after),
		.last        (last)
	);

	// Each wait state is entered with a nonzero attempt count, and retries only raise it.
	`PRTM_ASSERT_IMP(a_att_nonzero, state_q != prtm_pkg::ST_IDLE, att_q != '0,
		"attempt count is zero in a wait state")
	// The input side only stalls behind an item held in the input register.
	`PRTM_ASSERT_IMP(a_stall_held, in_stall, v_s1, "input stalled with an empty input register")
	// The output only goes quiet after the final action of an item has been taken.
	`PRTM_ASSERT_IMP(a_out_drop, $fell(out_valid), $past(out_valid && !out_stall && last),
		"output valid dropped before the last action was taken")
	// A committed item with actions shows them in the next cycle.
	`PRTM_ASSERT_NXT(a_commit_shows, commit && nxt.num != 2'd0, out_valid,
		"committed actions not presented")

endmodule

// ===== verif/poll_retry_timeout_master_fsm_core_tb.sv =====
// Self-checking testbench for the poll, retry and timeout controller core.
// Needs prtm_pkg and poll_retry_timeout_master_fsm_core; it predicts every action
// from its own model of the state machine and compares each output transaction.
module poll_retry_timeout_master_fsm_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prtm_pkg::*;

	// Cycles to let pass after the last expected action before touching the
	// registers or ending the run.
	localparam int SETTLE_CYCLES = 4;
	// Cycles without any transaction on any channel before the run is given up.
	localparam int QUIET_LIMIT = 1000;
	// Length of the long receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		action_t    act;
		logic [2:0] st;
		logic       fin;
	} action_rec_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms     = '0;
	logic [3:0]  event_code = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [2:0]  action;
	logic [2:0]  state_after;
	logic        last;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index  = '0;
	logic [15:0] cfg_data   = '0;

	poll_retry_timeout_master_fsm_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.event_code (event_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.state_after(state_after),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Model copy of the configuration registers, with their reset values.
	logic [15:0] to_data_ms    = TO_RESET;
	logic [15:0] to_ack_ms     = TO_RESET;
	logic [15:0] to_fail_ms    = TO_RESET;
	logic [15:0] to_cap_ms     = TO_RESET;
	logic [15:0] to_recon_ms   = TO_RESET;
	logic [3:0]  attempt_limit = MAX_ATT_RESET;

	// Model copy of the controller state.
	logic [2:0]  fsm_code = CODE_IDLE;
	logic [31:0] armed_at = '0;
	logic [3:0]  tries    = '0;

	// Actions still owed by the block, oldest first.
	action_rec_t expected_actions[$];

	int unsigned error_count  = 0;
	logic [31:0] clock_ms     = '0;
	bit          gaps_on      = 1'b1;
	int unsigned burst_left   = 0;
	int unsigned hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: %s", $realtime, msg);
	endtask

	// Works out the actions that one accepted input causes and queues them.
	// Each action carries the state right after the transition that goes
	// with it, and the final action of the input carries the last flag.
	task automatic predict_actions(input logic [31:0] now, input logic [3:0] ev);
		action_rec_t fresh[$];
		logic [31:0] elapsed;
		logic [15:0] limit;
		logic        retry_en;
		logic        fail_en;
		logic        gave_up;
		logic        is_wait;
		action_t     retry_act;
		action_t     fail_act;
		logic [3:0]  reply;

		elapsed   = now - armed_at;
		limit     = '0;
		retry_en  = 1'b0;
		fail_en   = 1'b0;
		gave_up   = 1'b0;
		is_wait   = 1'b1;
		retry_act = ACT_POLL;
		fail_act  = ACT_ERROR;
		reply     = EV_NONE;

		case (fsm_code)
			CODE_DATA: begin
				limit = to_data_ms;
				retry_en = 1'b1;
				fail_en = 1'b1;
				retry_act = ACT_POLL;
				reply = EV_DATA;
			end
			CODE_ACKDIR: begin
				limit = to_ack_ms;
				retry_en = 1'b1;
				fail_en = 1'b1;
				retry_act = ACT_DIRECTIVE;
				reply = EV_ACK;
			end
			CODE_FAIL: begin
				limit = to_fail_ms;
				reply = EV_FAILRX;
			end
			CODE_CAP: begin
				limit = to_cap_ms;
				reply = EV_CAPRX;
			end
			CODE_RECON: begin
				limit = to_recon_ms;
				reply = EV_RECONRX;
			end
			default: is_wait = 1'b0;
		endcase

		if (fsm_code == CODE_ACKRECON) begin
			// The acknowledge wait after a recon reply never retries.
			if (elapsed >= to_ack_ms) begin
				fsm_code = CODE_IDLE;
				fresh.push_back('{ACT_ERROR, fsm_code, 1'b0});
			end else if (ev == EV_ACK) begin
				fsm_code = CODE_IDLE;
				fresh.push_back('{ACT_ACK1, fsm_code, 1'b0});
			end
		end else if (is_wait) begin
			// The timeout check comes first; a give-up drops the reply.
			if (elapsed >= limit) begin
				if (tries < attempt_limit) begin
					armed_at = now;
					tries = tries + 4'd1;
					if (retry_en)
						fresh.push_back('{retry_act, fsm_code, 1'b0});
				end else begin
					gave_up = 1'b1;
					fsm_code = CODE_IDLE;
					if (fail_en)
						fresh.push_back('{fail_act, fsm_code, 1'b0});
				end
			end
			if (!gave_up && ev == reply) begin
				case (fsm_code)
					CODE_DATA: begin
						fsm_code = CODE_IDLE;
						fresh.push_back('{ACT_FORWARD, fsm_code, 1'b0});
						fresh.push_back('{ACT_ACK3, fsm_code, 1'b0});
					end
					CODE_ACKDIR: begin
						fsm_code = CODE_IDLE;
						fresh.push_back('{ACT_OK, fsm_code, 1'b0});
						fresh.push_back('{ACT_ACK3, fsm_code, 1'b0});
					end
					CODE_RECON: begin
						fsm_code = CODE_ACKRECON;
						armed_at = now;
					end
					default: begin
						fsm_code = CODE_IDLE;
						fresh.push_back('{ACT_ACK3, fsm_code, 1'b0});
					end
				endcase
			end
		end else begin
			// Idle, and any unknown state, takes requests.
			fsm_code = CODE_IDLE;
			case (ev)
				EV_CLKRST: begin
					fresh.push_back('{ACT_CLKRST, fsm_code, 1'b0});
					fresh.push_back('{ACT_OK, fsm_code, 1'b0});
				end
				EV_DIRECTIVE: begin
					fsm_code = CODE_ACKDIR;
					armed_at = now;
					tries = 4'd1;
					fresh.push_back('{ACT_DIRECTIVE, fsm_code, 1'b0});
				end
				EV_MEASURE: begin
					fsm_code = CODE_DATA;
					armed_at = now;
					tries = 4'd1;
					fresh.push_back('{ACT_POLL, fsm_code, 1'b0});
				end
				EV_FAILURES: begin
					fsm_code = CODE_FAIL;
					armed_at = now;
					tries = 4'd1;
				end
				EV_CAPACITY: begin
					fsm_code = CODE_CAP;
					armed_at = now;
					tries = 4'd1;
				end
				EV_RECON: begin
					fsm_code = CODE_RECON;
					armed_at = now;
					tries = 4'd1;
				end
				default: ;
			endcase
		end

		if (fresh.size() != 0)
			fresh[fresh.size() - 1].fin = 1'b1;
		foreach (fresh[i])
			expected_actions.push_back(fresh[i]);
	endtask

	// Offers one input transaction and waits until the block takes it. The
	// valid stays high after acceptance, so back-to-back items keep it up;
	// the end of a burst lowers it for a random gap.
	task automatic offer(input logic [31:0] now, input logic [3:0] ev);
		@(negedge clk);
		in_valid <= 1'b1;
		now_ms <= now;
		event_code <= ev;
		do @(posedge clk); while (in_stall !== 1'b0);
		clock_ms = now;
		predict_actions(now, ev);
		if (gaps_on) begin
			if (burst_left == 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 5) + (($urandom_range(0, 7) == 0) ? 15 : 0))
					@(negedge clk);
				burst_left = $urandom_range(0, 7);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Sends an event dt milliseconds after the previous item.
	task automatic step_ms(input logic [31:0] dt, input logic [3:0] ev);
		offer(clock_ms + dt, ev);
	endtask

	// Lowers the input valid and waits until every expected action has come
	// out, then the settle time too, since silent items leave nothing to wait on.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one configuration register and mirrors it in the model.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_TO_DATA:     to_data_ms = val;
			REG_TO_ACK:      to_ack_ms = val;
			REG_TO_FAILURES: to_fail_ms = val;
			REG_TO_CAPACITY: to_cap_ms = val;
			REG_TO_RECON:    to_recon_ms = val;
			REG_MAX_ATT:     attempt_limit = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_timeouts(input logic [15:0] val);
		write_reg(REG_TO_DATA, val);
		write_reg(REG_TO_ACK, val);
		write_reg(REG_TO_FAILURES, val);
		write_reg(REG_TO_CAPACITY, val);
		write_reg(REG_TO_RECON, val);
	endtask

	// Timeout values lean toward the extremes and toward short waits, so that
	// retries and give-ups come often.
	function automatic logic [15:0] pick_timeout();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'($urandom_range(2, 40));
			3: return TO_RESET;
			4: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	// One random item. Most items follow the protocol from the model's current
	// state: a request from idle, or the matching reply or nothing while
	// waiting, timed around the timeout boundary. The rest are noise.
	task automatic random_item();
		logic [3:0]  ev;
		logic [31:0] now;
		logic [31:0] lim;
		int unsigned pick;

		pick = $urandom_range(0, 99);
		case (fsm_code)
			CODE_DATA:                lim = 32'(to_data_ms);
			CODE_ACKDIR, CODE_ACKRECON: lim = 32'(to_ack_ms);
			CODE_FAIL:                lim = 32'(to_fail_ms);
			CODE_CAP:                 lim = 32'(to_cap_ms);
			CODE_RECON:               lim = 32'(to_recon_ms);
			default:                  lim = '0;
		endcase

		if (pick < 75) begin
			if (fsm_code == CODE_IDLE) begin
				ev = 4'($urandom_range(EV_CLKRST, EV_RECON));
				now = clock_ms + $urandom_range(0, 50);
			end else begin
				case (fsm_code)
					CODE_DATA:  ev = EV_DATA;
					CODE_FAIL:  ev = EV_FAILRX;
					CODE_CAP:   ev = EV_CAPRX;
					CODE_RECON: ev = EV_RECONRX;
					default:    ev = EV_ACK;
				endcase
				if ($urandom_range(0, 3) == 0)
					ev = EV_NONE;
				case ($urandom_range(0, 2))
					0: now = armed_at + $urandom_range(0, lim);
					1: now = armed_at + lim - 1 + $urandom_range(0, 2);
					default: now = armed_at + lim + $urandom_range(0, 100);
				endcase
			end
		end else begin
			ev = 4'($urandom_range(0, 15));
			now = (pick < 90) ? clock_ms + $urandom_range(0, 3000) : $urandom();
		end
		offer(now, ev);
	endtask

	// Every request and reply with the reset timeouts, timeout boundaries,
	// retries and give-ups, wrap of the millisecond time and unknown events.
	task automatic test_directed();
		clock_ms = 32'hFFFF_FE00;
		step_ms(0, EV_NONE);
		step_ms(1, EV_CLKRST);
		step_ms(1, EV_DIRECTIVE);
		step_ms(5, EV_DATA);          // wrong reply while waiting: dropped
		step_ms(994, EV_ACK);         // one below the timeout, across the time wrap
		step_ms(1, EV_MEASURE);
		step_ms(1000, EV_DATA);       // retry and reply in one item: three actions
		step_ms(1, EV_MEASURE);
		step_ms(1000, EV_NONE);
		step_ms(1000, 4'd12);
		step_ms(1000, EV_DATA);       // give-up reports error and drops the reply
		step_ms(1, EV_FAILURES);
		step_ms(1000, EV_NONE);       // silent retry
		step_ms(3, EV_FAILRX);
		step_ms(1, EV_CAPACITY);
		step_ms(2000, EV_CAPRX);
		step_ms(1, EV_RECON);
		step_ms(10, EV_RECONRX);
		step_ms(999, EV_ACK);
		step_ms(1, EV_RECON);
		step_ms(1, EV_RECONRX);
		step_ms(1000, EV_ACK);        // acknowledge wait times out with error
		step_ms(1, EV_DIRECTIVE);
		step_ms(1000, 4'd13);
		step_ms(1000, EV_NONE);
		step_ms(1000, EV_ACK);
		offer(32'hFFFF_FFFF, 4'd14);
		offer(32'h0000_0000, 4'd15);
		step_ms(1, EV_FAILRX);        // reply with nothing outstanding
	endtask

	// Extremes of the registers: zero timeouts, attempt limits of one, zero
	// and fifteen, the largest timeouts and writes to unused indexes.
	task automatic test_register_limits();
		wait_quiet();
		write_timeouts(16'd0);
		write_reg(REG_MAX_ATT, 16'd1);
		step_ms(7, EV_MEASURE);
		step_ms(0, EV_DATA);
		step_ms(1, EV_FAILURES);
		step_ms(0, EV_FAILRX);
		step_ms(1, EV_RECON);
		step_ms(0, EV_RECONRX);
		wait_quiet();
		write_reg(REG_MAX_ATT, 16'd0);
		step_ms(1, EV_CAPACITY);
		step_ms(5, EV_CAPRX);
		step_ms(1, EV_DIRECTIVE);
		step_ms(0, EV_ACK);
		wait_quiet();
		write_timeouts(16'hFFFF);
		write_reg(REG_MAX_ATT, 16'hFFFF);
		step_ms(1, EV_MEASURE);
		step_ms(65534, EV_DATA);
		step_ms(1, EV_DIRECTIVE);
		repeat (15) step_ms(65535, EV_NONE);
		step_ms(1, EV_RECON);
		step_ms(65535, EV_RECONRX);
		step_ms(65535, EV_ACK);
		wait_quiet();
		// Writes past the last register must change nothing.
		write_reg(3'd6, 16'($urandom()));
		write_reg(3'd7, 16'($urandom()));
		step_ms(1, EV_MEASURE);
		step_ms(65535, EV_NONE);
		step_ms(1, EV_DATA);
	endtask

	// Several random register settings, each followed by random items.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			wait_quiet();
			write_reg(REG_TO_DATA, pick_timeout());
			write_reg(REG_TO_ACK, pick_timeout());
			write_reg(REG_TO_FAILURES, pick_timeout());
			write_reg(REG_TO_CAPACITY, pick_timeout());
			write_reg(REG_TO_RECON, pick_timeout());
			case ($urandom_range(0, 5))
				0: write_reg(REG_MAX_ATT, 16'd0);
				1: write_reg(REG_MAX_ATT, 16'd1);
				2: write_reg(REG_MAX_ATT, 16'd15);
				default: write_reg(REG_MAX_ATT, 16'($urandom()));
			endcase
			if ($urandom_range(0, 1) == 0)
				write_reg(3'($urandom_range(6, 7)), 16'($urandom()));
			// The first phase runs without gaps on the input side.
			gaps_on = (phase != 0);
			repeat (5) random_item();
		end
		gaps_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering items with one to three actions each, so that the block fills
	// up and stalls its input. Afterwards the sender waits for every action.
	task automatic test_backpressure();
		wait_quiet();
		// Zero timeouts and attempts force the block back to idle at once.
		write_timeouts(16'd0);
		write_reg(REG_MAX_ATT, 16'd0);
		step_ms(1, EV_NONE);
		wait_quiet();
		write_timeouts(TO_RESET);
		write_reg(REG_MAX_ATT, 16'(MAX_ATT_RESET));
		gaps_on = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (4) begin
			step_ms(1, EV_CLKRST);
			step_ms(1, EV_MEASURE);
			step_ms(1000, EV_DATA);
		end
		gaps_on = 1'b1;
		wait_quiet();
	endtask

	// The receiver switches among random stall patterns and
	// serves the long hold-off when one is asked for.
	initial begin : receiver
		int unsigned phase;
		int unsigned held;
		stall_mode_t mode;
		phase = 0;
		held = 0;
		mode = STALL_NONE;
		forever begin
			@(negedge clk);
			if (held == 0 && hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
			end
			if (held != 0) begin
				out_stall <= 1'b1;
				held--;
			end else begin
				if (phase % 48 == 0)
					mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
				case (mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
					STALL_PERIODIC: out_stall <= ((phase % 5) < 2);
					default:        out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
			phase++;
		end
	end

	// Every output transaction is compared with the oldest expected action.
	initial begin : result_check
		action_rec_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_actions.size() == 0) begin
					report_mismatch($sformatf("unexpected action %0d state %0d last %0b",
						action, state_after, last));
				end else begin
					want = expected_actions.pop_front();
					if (action !== want.act || state_after !== want.st || last !== want.fin)
						report_mismatch($sformatf(
							"got action %0d state %0d last %0b, wanted %0d %0d %0b",
							action, state_after, last, want.act, want.st, want.fin));
				end
			end
		end
	end

	// Ends the run when no channel has moved a transaction for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("poll_retry_timeout_master_fsm_core: mismatch");
		$finish;
	end

	initial begin : main
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_register_limits();
		test_random_traffic();
		test_backpressure();

		// Anything still expected is caught here; then let trailing actions show.
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_actions.size() == 0)
			$display("poll_retry_timeout_master_fsm_core: match");
		else
			$display("poll_retry_timeout_master_fsm_core: mismatch");
		$finish;
	end

endmodule
